// ===== hw/rtl/lpi_pkg.sv =====
// Shared types and constants for the line pair intersection block.
package lpi_pkg;

	localparam int OUT_BITS = 48;

	typedef enum logic [1:0] {
		REL_POINT    = 2'd0,
		REL_PARALLEL = 2'd1,
		REL_SAME     = 2'd2,
		REL_DEGEN    = 2'd3
	} relation_t;

endpackage

// ===== hw/rtl/lpi_front.sv =====
// Front part: accepts requests, forms cross products and classifies the pair.
module lpi_front import lpi_pkg::*; #(
	parameter int COORD_BITS = 11,
	parameter int FRAC_BITS  = 8,
	localparam int CW = COORD_BITS,
	localparam int DW = CW + 1,
	localparam int PW = 2 * DW + 1,
	localparam int NW = CW + PW + 2 + FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] x1,
	input  logic signed [CW-1:0] y1,
	input  logic signed [CW-1:0] x2,
	input  logic signed [CW-1:0] y2,
	input  logic signed [CW-1:0] x3,
	input  logic signed [CW-1:0] y3,
	input  logic signed [CW-1:0] x4,
	input  logic signed [CW-1:0] y4,
	output logic                 out_valid,
	input  logic                 out_ready,
	output relation_t            rel,
	output logic signed [NW-1:0] nx,
	output logic signed [NW-1:0] ny,
	output logic        [PW-1:0] den
);
	// Stage 1: differences and all cross products.
	logic                 v_s1;
	logic signed [CW-1:0] x1_s1, y1_s1;
	logic signed [DW-1:0] d1x_s1, d1y_s1;
	logic signed [PW-1:0] den_s1, num_s1, col_s1;
	logic                 degen_s1;
	// Stage 2: numerators with the sign of the determinant folded in.
	logic                 v_s2;
	relation_t            rel_s2;
	logic signed [NW-1:0] nx_s2, ny_s2;
	logic        [PW-1:0] den_s2;

	logic signed [DW-1:0] d1x, d1y, d2x, d2y, ex, ey;
	logic                 adv1, adv2;
	logic signed [PW-1:0] an, ad;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign d1x = DW'(x2) - DW'(x1);
	assign d1y = DW'(y2) - DW'(y1);
	assign d2x = DW'(x4) - DW'(x3);
	assign d2y = DW'(y4) - DW'(y3);
	assign ex  = DW'(x3) - DW'(x1);
	assign ey  = DW'(y3) - DW'(y1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			x1_s1    <= x1;
			y1_s1    <= y1;
			d1x_s1   <= d1x;
			d1y_s1   <= d1y;
			degen_s1 <= (d1x == '0 && d1y == '0) || (d2x == '0 && d2y == '0);
			den_s1   <= PW'(d1x * d2y) - PW'(d1y * d2x);
			num_s1   <= PW'(ex * d2y) - PW'(ey * d2x);
			col_s1   <= PW'(ex * d1y) - PW'(ey * d1x);
		end
	end

	assign an = den_s1[PW-1] ? -num_s1 : num_s1;
	assign ad = den_s1[PW-1] ? -den_s1 : den_s1;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			den_s2 <= ad;
			nx_s2  <= (NW'(x1_s1) * NW'(ad) + NW'(d1x_s1) * NW'(an)) <<< FRAC_BITS;
			ny_s2  <= (NW'(y1_s1) * NW'(ad) + NW'(d1y_s1) * NW'(an)) <<< FRAC_BITS;
			if (degen_s1)
				rel_s2 <= REL_DEGEN;
			else if (den_s1 != '0)
				rel_s2 <= REL_POINT;
			else if (col_s1 == '0)
				rel_s2 <= REL_SAME;
			else
				rel_s2 <= REL_PARALLEL;
		end
	end

	assign out_valid = v_s2;
	assign rel       = rel_s2;
	assign nx        = nx_s2;
	assign ny        = ny_s2;
	assign den       = den_s2;
endmodule

// ===== hw/rtl/lpi_fifo.sv =====
// Short queue between the front and back parts.
module lpi_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

// ===== hw/rtl/lpi_back.sv =====
// Back part: pipelined rounding divider producing the meeting point.
module lpi_back import lpi_pkg::*; #(
	parameter int PW = 25,
	parameter int NW = 44
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  relation_t                  in_rel,
	input  logic signed [NW-1:0]       in_nx,
	input  logic signed [NW-1:0]       in_ny,
	input  logic        [PW-1:0]       in_den,
	output logic                       out_valid,
	input  logic                       out_ready,
	output relation_t                  rel,
	output logic signed [OUT_BITS-1:0] meet_x,
	output logic signed [OUT_BITS-1:0] meet_y
);
	// Restoring division, one quotient bit per stage, on 2|n|+d over 2d.
	localparam int MW = NW + 1;
	localparam int RW = PW + 2;
	localparam int ST = MW;

	logic            v_q   [ST+1];
	relation_t       rel_q [ST+1];
	logic            sx_q  [ST+1];
	logic            sy_q  [ST+1];
	logic [RW-1:0]   dd_q  [ST+1];
	logic [MW-1:0]   ax_q  [ST+1];
	logic [MW-1:0]   ay_q  [ST+1];
	logic [RW-1:0]   rx_q  [ST+1];
	logic [RW-1:0]   ry_q  [ST+1];
	logic [MW-1:0]   qx_q  [ST+1];
	logic [MW-1:0]   qy_q  [ST+1];
	logic            adv;
	logic            ov_point;
	logic [OUT_BITS-1:0] ox, oy;

	assign adv      = !v_q[ST] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ST; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i <= ST; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [MW-1:0] mx, my;
		logic [RW-1:0] tx, ty;
		if (adv) begin
			mx = in_nx[NW-1] ? MW'(-in_nx) : MW'(in_nx);
			my = in_ny[NW-1] ? MW'(-in_ny) : MW'(in_ny);
			rel_q[0] <= in_rel;
			sx_q[0]  <= in_nx[NW-1];
			sy_q[0]  <= in_ny[NW-1];
			dd_q[0]  <= RW'({in_den, 1'b0});
			ax_q[0]  <= (mx << 1) + MW'(in_den);
			ay_q[0]  <= (my << 1) + MW'(in_den);
			rx_q[0]  <= '0;
			ry_q[0]  <= '0;
			qx_q[0]  <= '0;
			qy_q[0]  <= '0;
			for (int i = 1; i <= ST; i++) begin
				rel_q[i] <= rel_q[i-1];
				sx_q[i]  <= sx_q[i-1];
				sy_q[i]  <= sy_q[i-1];
				dd_q[i]  <= dd_q[i-1];
				ax_q[i]  <= ax_q[i-1] << 1;
				ay_q[i]  <= ay_q[i-1] << 1;
				tx = {rx_q[i-1][RW-2:0], ax_q[i-1][MW-1]};
				ty = {ry_q[i-1][RW-2:0], ay_q[i-1][MW-1]};
				if (tx >= dd_q[i-1]) begin
					rx_q[i] <= tx - dd_q[i-1];
					qx_q[i] <= {qx_q[i-1][MW-2:0], 1'b1};
				end else begin
					rx_q[i] <= tx;
					qx_q[i] <= {qx_q[i-1][MW-2:0], 1'b0};
				end
				if (ty >= dd_q[i-1]) begin
					ry_q[i] <= ty - dd_q[i-1];
					qy_q[i] <= {qy_q[i-1][MW-2:0], 1'b1};
				end else begin
					ry_q[i] <= ty;
					qy_q[i] <= {qy_q[i-1][MW-2:0], 1'b0};
				end
			end
		end
	end

	// Saturate magnitude and apply sign.
	function automatic logic [OUT_BITS-1:0] fin(input logic [MW-1:0] q, input logic s);
		logic [MW:0] lim;
		lim = (MW+1)'({1'b0, {(OUT_BITS-1){1'b1}}}) + (MW+1)'(s);
		if ((MW+1)'(q) > lim)
			q = MW'(lim);
		fin = s ? OUT_BITS'(-(OUT_BITS+MW)'(q)) : OUT_BITS'(q);
	endfunction

	assign ox = fin(qx_q[ST], sx_q[ST]);
	assign oy = fin(qy_q[ST], sy_q[ST]);
	assign ov_point  = rel_q[ST] == REL_POINT;
	assign out_valid = v_q[ST];
	assign rel       = rel_q[ST];
	assign meet_x    = ov_point ? ox : '0;
	assign meet_y    = ov_point ? oy : '0;
endmodule

// ===== hw/rtl/line_pair_intersection.sv =====
// Top level of the line pair intersection block.
//
// Usage: each request on the slave stream carries two lines, each given by
// two integer points, packed in s_axis_tdata. The master stream returns one
// result per request: the relation code in m_axis_tuser and the meeting
// point in m_axis_tdata, as signed fixed point with FRAC_BITS fraction bits.
// The front part forms the cross products and classifies the pair in two
// register stages; a two-entry queue then feeds the back part, a pipelined
// rounding divider with an input stage and one stage per quotient bit
// (3*COORD_BITS+FRAC_BITS+7 stages, 48 at the default settings).
// Throughput is one request per cycle while the receiver accepts results; a
// request passes through the two front stages, a queue entry and then the
// divider stages before its result is valid.
// Reset clears every valid flag at once; no clearing pass is needed.
// When the receiver stalls, the whole divider holds, empty stages included;
// the queue then fills and the front holds, so s_axis_tready drops once the
// queue and both front stages are full.
module line_pair_intersection import lpi_pkg::*; #(
	parameter int COORD_BITS = 11,
	parameter int FRAC_BITS  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// meet_x, meet_y
	output logic [2*OUT_BITS-1:0]      m_axis_tdata,
	// relation
	output logic [1:0]                 m_axis_tuser
);
	localparam int CW = COORD_BITS;
	localparam int PW = 2 * (CW + 1) + 1;
	localparam int NW = CW + PW + 2 + FRAC_BITS;
	localparam int QW = 2 + 2 * NW + PW;

	relation_t            f_rel, b_rel_in, b_rel;
	logic signed [NW-1:0] f_nx, f_ny;
	logic        [PW-1:0] f_den;
	logic                 f_v, f_r, q_v, q_r;
	logic [QW-1:0]        q_in, q_out;
	logic signed [OUT_BITS-1:0] mx, my;

	lpi_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
		.x1 (s_axis_tdata[0*CW +: CW]), .y1 (s_axis_tdata[1*CW +: CW]),
		.x2 (s_axis_tdata[2*CW +: CW]), .y2 (s_axis_tdata[3*CW +: CW]),
		.x3 (s_axis_tdata[4*CW +: CW]), .y3 (s_axis_tdata[5*CW +: CW]),
		.x4 (s_axis_tdata[6*CW +: CW]), .y4 (s_axis_tdata[7*CW +: CW]),
		.out_valid (f_v), .out_ready (f_r),
		.rel (f_rel), .nx (f_nx), .ny (f_ny), .den (f_den)
	);

	assign q_in = {f_rel, f_nx, f_ny, f_den};

	lpi_fifo #(.WIDTH(QW)) u_fifo (
		.clk, .arst_n,
		.in_valid (f_v), .in_ready (f_r), .in_data (q_in),
		.out_valid (q_v), .out_ready (q_r), .out_data (q_out)
	);

	assign b_rel_in = relation_t'(q_out[QW-1 -: 2]);

	lpi_back #(.PW(PW), .NW(NW)) u_back (
		.clk, .arst_n,
		.in_valid (q_v), .in_ready (q_r),
		.in_rel (b_rel_in),
		.in_nx (q_out[PW+NW +: NW]), .in_ny (q_out[PW +: NW]),
		.in_den (q_out[PW-1:0]),
		.out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
		.rel (b_rel), .meet_x (mx), .meet_y (my)
	);

	assign m_axis_tdata = {my, mx};
	assign m_axis_tuser = b_rel;
endmodule
